>>> hw/rtl/fdsa_pkg.sv
// Shared constants, codes, memory request types and helpers of the sector allocator.
`default_nettype none

package fdsa_pkg;

  // Geometry
  localparam int unsigned DIR_ENTRIES      = 16;
  localparam int unsigned SECTORS_PER_FILE = 26;
  localparam int unsigned SECTOR_COUNT     = 256;

  // Field widths
  localparam int unsigned OP_W     = 2;
  localparam int unsigned NAME_W   = 48;
  localparam int unsigned CNT_W    = 5;
  localparam int unsigned SECTOR_W = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned BYTE_W   = 8;

  // Derived widths
  localparam int unsigned ENT_W     = (DIR_ENTRIES > 1) ? $clog2(DIR_ENTRIES) : 1;
  localparam int unsigned K_W       = $clog2(SECTORS_PER_FILE + 1);
  localparam int unsigned SEC_DEPTH = DIR_ENTRIES * SECTORS_PER_FILE;
  localparam int unsigned SEC_AW    = (SEC_DEPTH > 1) ? $clog2(SEC_DEPTH) : 1;
  localparam int unsigned ROW_BITS  = 8;
  localparam int unsigned BIT_W     = $clog2(ROW_BITS);
  localparam int unsigned MAP_ROWS  = (SECTOR_COUNT + ROW_BITS - 1) / ROW_BITS;
  localparam int unsigned ROW_W     = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;
  localparam int unsigned CUR_W     = SECTOR_W + 1;

  localparam logic [SECTOR_W-1:0] RESERVED_RESET = SECTOR_W'(3);

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_DELETE = 2'd1,
    OP_CREATE = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_DIR_FULL  = 2'd2,
    ST_DISK_FULL = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_NEXT,
    S_SEC_RD,
    S_SEC_DATA,
    S_CLR_RD,
    S_CLR_WR,
    S_ALLOC_RD,
    S_ALLOC_CHK,
    S_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic              we;
    logic [ENT_W-1:0]  waddr;
    logic [NAME_W-1:0] wdata;
    logic              re;
    logic [ENT_W-1:0]  raddr;
  } name_req_t;

  typedef struct packed {
    logic                we;
    logic [SEC_AW-1:0]   waddr;
    logic [SECTOR_W-1:0] wdata;
    logic                re;
    logic [SEC_AW-1:0]   raddr;
  } sec_req_t;

  typedef struct packed {
    logic                we;
    logic [ROW_W-1:0]    waddr;
    logic [ROW_BITS-1:0] wdata;
    logic                re;
    logic [ROW_W-1:0]    raddr;
  } map_req_t;

  // Address of slot k of a directory entry's sector list
  function automatic logic [SEC_AW-1:0] sec_addr(input logic [ENT_W-1:0] ent,
                                                 input logic [K_W-1:0] k);
    logic [SEC_AW+ENT_W+K_W-1:0] full;
    full = (SEC_AW+ENT_W+K_W)'(ent) * (SEC_AW+ENT_W+K_W)'(SECTORS_PER_FILE)
         + (SEC_AW+ENT_W+K_W)'(k);
    return full[SEC_AW-1:0];
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/fdsa_if.sv
// Request, result and configuration channel interfaces of the sector allocator.
`default_nettype none

interface fdsa_req_if;
  logic                         valid;
  logic                         ready;
  logic [fdsa_pkg::OP_W-1:0]    op;
  logic [fdsa_pkg::NAME_W-1:0]  file_name;
  logic [fdsa_pkg::CNT_W-1:0]   sector_count;
  modport source (output valid, op, file_name, sector_count, input ready);
  modport sink (input valid, op, file_name, sector_count, output ready);
endinterface

interface fdsa_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [fdsa_pkg::SECTOR_W-1:0] sector;
  logic [fdsa_pkg::STATUS_W-1:0] status;
  logic                          last;
  modport source (output valid, sector, status, last, input ready);
  modport sink (input valid, sector, status, last, output ready);
endinterface

interface fdsa_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [fdsa_pkg::SECTOR_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/fdsa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module fdsa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and read; read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hw/rtl/fdsa_ctrl.sv
// Request sequencer: directory scan, sector list walk, map search and result register.
`default_nettype none

module fdsa_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  fdsa_req_if.sink                        req_i,
  fdsa_rsp_if.source                      rsp_o,
  fdsa_cfg_if.sink                        cfg_i,
  output fdsa_pkg::name_req_t             name_req_o,
  input  logic [fdsa_pkg::NAME_W-1:0]     name_rdata_i,
  output fdsa_pkg::sec_req_t              sec_req_o,
  input  logic [fdsa_pkg::SECTOR_W-1:0]   sec_rdata_i,
  output fdsa_pkg::map_req_t              map_req_o,
  input  logic [fdsa_pkg::ROW_BITS-1:0]   map_rdata_i
);

  localparam int unsigned DE  = fdsa_pkg::DIR_ENTRIES;
  localparam int unsigned RB  = fdsa_pkg::ROW_BITS;
  localparam int unsigned KW  = fdsa_pkg::K_W;
  localparam int unsigned EW  = fdsa_pkg::ENT_W;
  localparam int unsigned CW  = fdsa_pkg::CUR_W;
  localparam int unsigned SW  = fdsa_pkg::SECTOR_W;
  localparam int unsigned RW  = fdsa_pkg::ROW_W;
  localparam int unsigned BW  = fdsa_pkg::BIT_W;
  localparam int unsigned NW  = fdsa_pkg::NAME_W;

  fdsa_pkg::ctrl_state_e state_q, state_d;
  fdsa_pkg::op_e         op_q, op_d;
  fdsa_pkg::status_e     em_status_q, em_status_d;
  logic [NW-1:0]         name_q, name_d;
  logic [KW-1:0]         cnt_q, cnt_d;
  logic [KW-1:0]         k_q, k_d;
  logic [EW-1:0]         ent_q, ent_d;
  logic [CW-1:0]         cur_q, cur_d;
  logic [SW-1:0]         sec_q, sec_d;
  logic                  hit_q, hit_d;
  logic [SW-1:0]         res_q;

  logic [DE-1:0]         busy_q;
  logic [KW-1:0]         len_q [DE];
  logic [fdsa_pkg::MAP_ROWS-1:0] map_vld_q;

  logic                  out_vld_q;
  logic [SW-1:0]         out_sector_q;
  fdsa_pkg::status_e     out_status_q;
  logic                  out_last_q;

  // Decoded conditions
  logic                  req_fire, slot_free, req_name_ok;
  logic                  free_found;
  logic [EW-1:0]         free_ent;
  logic [KW-1:0]         cnt_sat, cur_len, k_inc;
  logic                  ent_match, k_last_len, k_last_cnt, disk_full;
  logic [SW-1:0]         lo;
  logic [RW-1:0]         cur_row, sec_row, map_row_idx;
  logic [RB-1:0]         map_row, avail;
  logic [BW-1:0]         alloc_bit;
  logic                  alloc_ok;
  logic [SW-1:0]         alloc_sector;
  logic [CW-1:0]         next_row_cur;

  // Datapath and update controls
  logic                  emit;
  logic [SW-1:0]         emit_sector;
  fdsa_pkg::status_e     emit_status;
  logic                  emit_last;
  logic                  set_busy, clr_busy, len_we;
  logic [EW-1:0]         busy_ent;
  logic [KW-1:0]         len_wdata;
  logic                  map_set_vld;

  assign req_fire    = req_i.valid && req_i.ready;
  assign slot_free   = !out_vld_q || rsp_o.ready;
  assign req_name_ok = |req_i.file_name[NW-1 -: fdsa_pkg::BYTE_W];
  assign cnt_sat     = (req_i.sector_count > fdsa_pkg::CNT_W'(fdsa_pkg::SECTORS_PER_FILE))
                       ? KW'(fdsa_pkg::SECTORS_PER_FILE) : KW'(req_i.sector_count);
  assign lo          = (res_q == '0) ? SW'(1) : res_q;
  assign cur_len     = len_q[ent_q];
  assign k_inc       = k_q + KW'(1);
  assign k_last_len  = (k_inc == cur_len);
  assign k_last_cnt  = (k_inc == cnt_q);
  assign ent_match   = busy_q[ent_q] && (name_rdata_i == name_q);
  assign disk_full   = (cur_q >= CW'(fdsa_pkg::SECTOR_COUNT));
  assign cur_row     = cur_q[BW +: RW];
  assign sec_row     = sec_q[BW +: RW];
  assign map_row_idx = ((state_q == fdsa_pkg::S_CLR_RD) || (state_q == fdsa_pkg::S_CLR_WR))
                       ? sec_row : cur_row;
  assign map_row     = map_vld_q[map_row_idx] ? map_rdata_i : '0;
  assign next_row_cur = (CW'(cur_row) + CW'(1)) << BW;
  assign alloc_sector = SW'({cur_row, alloc_bit});

  // Find the first free directory entry
  always_comb begin
    free_found = 1'b0;
    free_ent   = '0;
    for (int i = DE - 1; i >= 0; i--) begin
      if (!busy_q[i]) begin
        free_found = 1'b1;
        free_ent   = EW'(i);
      end
    end
  end

  // Find the lowest free sector at or above the cursor in the current row
  always_comb begin
    alloc_ok  = 1'b0;
    alloc_bit = '0;
    for (int i = 0; i < RB; i++) begin
      avail[i] = !map_row[i] && (BW'(i) >= cur_q[BW-1:0])
                 && (CW'({cur_row, BW'(i)}) < CW'(fdsa_pkg::SECTOR_COUNT));
    end
    for (int i = RB - 1; i >= 0; i--) begin
      if (avail[i]) begin
        alloc_ok  = 1'b1;
        alloc_bit = BW'(i);
      end
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fdsa_pkg::S_IDLE: begin
        if (req_fire) begin
          unique case (fdsa_pkg::op_e'(req_i.op))
            fdsa_pkg::OP_LOOKUP, fdsa_pkg::OP_DELETE:
              state_d = req_name_ok ? fdsa_pkg::S_SCAN_RD : fdsa_pkg::S_EMIT;
            fdsa_pkg::OP_CREATE:
              state_d = (req_name_ok && free_found && (cnt_sat != '0))
                        ? fdsa_pkg::S_ALLOC_RD : fdsa_pkg::S_EMIT;
            default: state_d = fdsa_pkg::S_IDLE;
          endcase
        end
      end
      fdsa_pkg::S_SCAN_RD: state_d = fdsa_pkg::S_SCAN_CMP;
      fdsa_pkg::S_SCAN_CMP: begin
        if (ent_match && (op_q == fdsa_pkg::OP_LOOKUP)) begin
          state_d = (cur_len == '0) ? fdsa_pkg::S_EMIT : fdsa_pkg::S_SEC_RD;
        end else if (ent_match && (cur_len != '0)) begin
          state_d = fdsa_pkg::S_SEC_RD;
        end else begin
          state_d = fdsa_pkg::S_NEXT;
        end
      end
      fdsa_pkg::S_NEXT:
        state_d = (ent_q == EW'(DE - 1)) ? fdsa_pkg::S_EMIT : fdsa_pkg::S_SCAN_RD;
      fdsa_pkg::S_SEC_RD: state_d = fdsa_pkg::S_SEC_DATA;
      fdsa_pkg::S_SEC_DATA: begin
        if (op_q == fdsa_pkg::OP_DELETE) begin
          state_d = fdsa_pkg::S_CLR_RD;
        end else if (slot_free) begin
          state_d = k_last_len ? fdsa_pkg::S_IDLE : fdsa_pkg::S_SEC_RD;
        end
      end
      fdsa_pkg::S_CLR_RD: state_d = fdsa_pkg::S_CLR_WR;
      fdsa_pkg::S_CLR_WR:
        state_d = k_last_len ? fdsa_pkg::S_NEXT : fdsa_pkg::S_SEC_RD;
      fdsa_pkg::S_ALLOC_RD:
        state_d = disk_full ? fdsa_pkg::S_EMIT : fdsa_pkg::S_ALLOC_CHK;
      fdsa_pkg::S_ALLOC_CHK: begin
        if (!alloc_ok) begin
          state_d = fdsa_pkg::S_ALLOC_RD;
        end else if (slot_free) begin
          state_d = k_last_cnt ? fdsa_pkg::S_IDLE : fdsa_pkg::S_ALLOC_RD;
        end
      end
      fdsa_pkg::S_EMIT:
        if (slot_free) state_d = fdsa_pkg::S_IDLE;
      default: state_d = fdsa_pkg::S_IDLE;
    endcase
  end

  // Datapath controls and memory requests
  always_comb begin
    op_d        = op_q;
    name_d      = name_q;
    cnt_d       = cnt_q;
    k_d         = k_q;
    ent_d       = ent_q;
    cur_d       = cur_q;
    sec_d       = sec_q;
    hit_d       = hit_q;
    em_status_d = em_status_q;
    emit        = 1'b0;
    emit_sector = '0;
    emit_status = fdsa_pkg::ST_OK;
    emit_last   = 1'b1;
    set_busy    = 1'b0;
    clr_busy    = 1'b0;
    len_we      = 1'b0;
    busy_ent    = ent_q;
    len_wdata   = '0;
    map_set_vld = 1'b0;
    name_req_o  = '0;
    sec_req_o   = '0;
    map_req_o   = '0;
    name_req_o.raddr = ent_q;
    sec_req_o.raddr  = fdsa_pkg::sec_addr(ent_q, k_q);
    sec_req_o.waddr  = fdsa_pkg::sec_addr(ent_q, k_q);
    map_req_o.raddr  = map_row_idx;
    map_req_o.waddr  = map_row_idx;
    unique case (state_q)
      fdsa_pkg::S_IDLE: begin
        if (req_fire) begin
          op_d        = fdsa_pkg::op_e'(req_i.op);
          name_d      = req_i.file_name;
          cnt_d       = cnt_sat;
          k_d         = '0;
          ent_d       = '0;
          hit_d       = 1'b0;
          cur_d       = CW'(lo);
          em_status_d = fdsa_pkg::ST_NOT_FOUND;
          if (fdsa_pkg::op_e'(req_i.op) == fdsa_pkg::OP_CREATE && req_name_ok) begin
            if (!free_found) begin
              em_status_d = fdsa_pkg::ST_DIR_FULL;
            end else begin
              // Claim the entry; its sector list is already empty
              em_status_d      = fdsa_pkg::ST_OK;
              ent_d            = free_ent;
              set_busy         = 1'b1;
              busy_ent         = free_ent;
              name_req_o.we    = 1'b1;
              name_req_o.waddr = free_ent;
              name_req_o.wdata = req_i.file_name;
            end
          end
        end
      end
      fdsa_pkg::S_SCAN_RD: name_req_o.re = 1'b1;
      fdsa_pkg::S_SCAN_CMP: begin
        k_d = '0;
        if (ent_match) begin
          hit_d       = 1'b1;
          em_status_d = fdsa_pkg::ST_OK;
          if ((op_q == fdsa_pkg::OP_DELETE) && (cur_len == '0)) begin
            clr_busy = 1'b1;
          end
        end
      end
      fdsa_pkg::S_NEXT: begin
        ent_d = ent_q + EW'(1);
        if (op_q == fdsa_pkg::OP_DELETE) begin
          em_status_d = hit_q ? fdsa_pkg::ST_OK : fdsa_pkg::ST_NOT_FOUND;
        end
      end
      fdsa_pkg::S_SEC_RD: sec_req_o.re = 1'b1;
      fdsa_pkg::S_SEC_DATA: begin
        sec_d = sec_rdata_i;
        if ((op_q == fdsa_pkg::OP_LOOKUP) && slot_free) begin
          emit        = 1'b1;
          emit_sector = sec_rdata_i;
          emit_last   = k_last_len;
          k_d         = k_inc;
        end
      end
      fdsa_pkg::S_CLR_RD: map_req_o.re = 1'b1;
      fdsa_pkg::S_CLR_WR: begin
        // Free the sector in the map and advance along the list
        map_req_o.we    = 1'b1;
        map_req_o.wdata = map_row & ~(RB'(1) << sec_q[BW-1:0]);
        map_set_vld     = 1'b1;
        k_d             = k_inc;
        if (k_last_len) begin
          clr_busy = 1'b1;
        end
      end
      fdsa_pkg::S_ALLOC_RD: begin
        map_req_o.re = !disk_full;
        if (disk_full) begin
          em_status_d = fdsa_pkg::ST_DISK_FULL;
        end
      end
      fdsa_pkg::S_ALLOC_CHK: begin
        if (!alloc_ok) begin
          cur_d = next_row_cur;
        end else if (slot_free) begin
          // Take the sector: mark it, record it, report it
          map_req_o.we    = 1'b1;
          map_req_o.wdata = map_row | (RB'(1) << alloc_bit);
          map_set_vld     = 1'b1;
          sec_req_o.we    = 1'b1;
          sec_req_o.wdata = alloc_sector;
          len_we          = 1'b1;
          len_wdata       = k_inc;
          emit            = 1'b1;
          emit_sector     = alloc_sector;
          emit_last       = k_last_cnt;
          k_d             = k_inc;
          cur_d           = CW'(alloc_sector) + CW'(1);
        end
      end
      fdsa_pkg::S_EMIT: begin
        emit        = slot_free;
        emit_status = em_status_q;
      end
      default: ;
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= fdsa_pkg::S_IDLE;
      res_q     <= fdsa_pkg::RESERVED_RESET;
      ent_q     <= '0;
      busy_q    <= '0;
      map_vld_q <= '0;
      out_vld_q <= 1'b0;
      for (int i = 0; i < DE; i++) len_q[i] <= '0;
    end else begin
      state_q <= state_d;
      ent_q   <= ent_d;
      if (cfg_i.valid && cfg_i.ready) res_q <= cfg_i.data;
      if (set_busy) busy_q[busy_ent] <= 1'b1;
      if (clr_busy) begin
        busy_q[busy_ent] <= 1'b0;
        len_q[busy_ent]  <= '0;
      end
      if (len_we) len_q[ent_q] <= len_wdata;
      if (map_set_vld) map_vld_q[map_row_idx] <= 1'b1;
      if (emit) out_vld_q <= 1'b1;
      else if (rsp_o.ready) out_vld_q <= 1'b0;
    end
  end

  // Hold request context and result payload
  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    name_q      <= name_d;
    cnt_q       <= cnt_d;
    k_q         <= k_d;
    cur_q       <= cur_d;
    sec_q       <= sec_d;
    hit_q       <= hit_d;
    em_status_q <= em_status_d;
    if (emit) begin
      out_sector_q <= emit_sector;
      out_status_q <= emit_status;
      out_last_q   <= emit_last;
    end
  end

  assign req_i.ready  = (state_q == fdsa_pkg::S_IDLE);
  assign cfg_i.ready  = 1'b1;
  assign rsp_o.valid  = out_vld_q;
  assign rsp_o.sector = out_sector_q;
  assign rsp_o.status = out_status_q;
  assign rsp_o.last   = out_last_q;

  // Map is never read and written in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(map_req_o.we && map_req_o.re))
    else $error("map read and write collide");

  // Allocated sectors never fall in the reserved range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_we && sec_req_o.we) |-> (sec_req_o.wdata >= lo))
    else $error("reserved sector allocated");

  // A free entry has an empty sector list
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q[ent_q] |-> (len_q[ent_q] == '0))
    else $error("free entry holds sectors");

  // List length stays within the entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q[ent_q] <= KW'(fdsa_pkg::SECTORS_PER_FILE))
    else $error("sector list overflow");

endmodule

`default_nettype wire

>>> hw/rtl/flat_directory_sector_allocator_top.sv
// Top level of the flat directory sector allocator: sequencer and its three memories.
//
// Usage: requests arrive on req_i (op, file_name, sector_count) and are taken
// only while no earlier request is in progress. Each lookup, delete or create
// request produces one or more results on rsp_o (sector, status, last); last
// marks the final one. cfg_i writes the reserved sector bound at any time the
// block is idle. Lookup and delete scan the directory memory entry by entry
// (read, compare, next); a lookup hit then reads the sector list one sector at
// a time (read, data). Delete reads each listed sector and frees it in the map
// (list read plus map read-modify-write). Create reads and checks the map one
// 8-sector row at a time, moving on to the next row when it holds no free
// sector; a full disk costs one pass over the map rows.
// One result register decouples the receiver: a stalled rsp_o holds that
// result and pauses the sequencer until it is taken.
// Reset empties the directory and the used-sector map at once through
// per-entry and per-row valid flops; no clearing pass is needed, and the
// reserved bound returns to 3.
`default_nettype none

module flat_directory_sector_allocator_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  fdsa_req_if.sink   req_i,
  fdsa_rsp_if.source rsp_o,
  fdsa_cfg_if.sink   cfg_i
);

  fdsa_pkg::name_req_t                 name_req;
  fdsa_pkg::sec_req_t                  sec_req;
  fdsa_pkg::map_req_t                  map_req;
  logic [fdsa_pkg::NAME_W-1:0]         name_rdata;
  logic [fdsa_pkg::SECTOR_W-1:0]       sec_rdata;
  logic [fdsa_pkg::ROW_BITS-1:0]       map_rdata;

  // Sequence requests
  fdsa_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .rsp_o        (rsp_o),
    .cfg_i        (cfg_i),
    .name_req_o   (name_req),
    .name_rdata_i (name_rdata),
    .sec_req_o    (sec_req),
    .sec_rdata_i  (sec_rdata),
    .map_req_o    (map_req),
    .map_rdata_i  (map_rdata)
  );

  // Directory names
  fdsa_ram #(
    .WIDTH (fdsa_pkg::NAME_W),
    .DEPTH (fdsa_pkg::DIR_ENTRIES)
  ) u_name_ram (
    .clk_i   (clk_i),
    .we_i    (name_req.we),
    .waddr_i (name_req.waddr),
    .wdata_i (name_req.wdata),
    .re_i    (name_req.re),
    .raddr_i (name_req.raddr),
    .rdata_o (name_rdata)
  );

  // Per-entry sector lists
  fdsa_ram #(
    .WIDTH (fdsa_pkg::SECTOR_W),
    .DEPTH (fdsa_pkg::SEC_DEPTH)
  ) u_sec_ram (
    .clk_i   (clk_i),
    .we_i    (sec_req.we),
    .waddr_i (sec_req.waddr),
    .wdata_i (sec_req.wdata),
    .re_i    (sec_req.re),
    .raddr_i (sec_req.raddr),
    .rdata_o (sec_rdata)
  );

  // Used-sector map, one row of sectors per word
  fdsa_ram #(
    .WIDTH (fdsa_pkg::ROW_BITS),
    .DEPTH (fdsa_pkg::MAP_ROWS)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_req.we),
    .waddr_i (map_req.waddr),
    .wdata_i (map_req.wdata),
    .re_i    (map_req.re),
    .raddr_i (map_req.raddr),
    .rdata_o (map_rdata)
  );

endmodule

`default_nettype wire
